### hw/rtl/lbp_pkg.sv
// Shared constants and types for the 3x3 local binary pattern stream core.
package lbp_pkg;

  localparam int IMAGE_SIZE = 128;
  localparam int CNT_W      = $clog2(IMAGE_SIZE);
  localparam int PIX_W      = 8;
  localparam int COORD_W    = 7;
  localparam int CODE_W     = 8;

  // gray = floor(sum / 3) as (sum * 683) >> 11, exact for sums up to 765
  localparam int SUM_W      = PIX_W + 2;
  localparam int DIV3_MUL   = 683;
  localparam int DIV3_SHIFT = 11;
  localparam int PROD_W     = 20;

  typedef logic [PIX_W-1:0]   gray_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [CODE_W-1:0]  code_t;

  // one new window column: two stored rows above plus the incoming pixel
  typedef struct packed {
    gray_t top;
    gray_t mid;
    gray_t cur;
  } column_t;

endpackage

### hw/rtl/lbp_gray.sv
// RGB to gray conversion: truncated mean of the three channels.
module lbp_gray import lbp_pkg::*; (
  input  logic [PIX_W-1:0] blue,
  input  logic [PIX_W-1:0] green,
  input  logic [PIX_W-1:0] red,
  output gray_t            gray
);

  logic [SUM_W-1:0]  sum;
  logic [PROD_W-1:0] prod;

  assign sum  = SUM_W'(blue) + SUM_W'(green) + SUM_W'(red);
  assign prod = PROD_W'(sum) * PROD_W'(DIV3_MUL);
  assign gray = prod[DIV3_SHIFT +: PIX_W];

endmodule

### hw/rtl/lbp_line_store.sv
// Two-row line store: each word holds the gray values of the two previous rows.
module lbp_line_store import lbp_pkg::*; (
  input  logic               clk,
  input  logic               rd_en,
  input  cnt_t               rd_addr,
  output logic [2*PIX_W-1:0] rd_data,
  input  logic               wr_en,
  input  cnt_t               wr_addr,
  input  logic [2*PIX_W-1:0] wr_data
);

  logic [2*PIX_W-1:0] mem [IMAGE_SIZE];

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

endmodule

### hw/rtl/lbp_window.sv
// 3x3 gray window and the 8-neighbour comparison that forms the code.
module lbp_window import lbp_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    shift_en,
  input  column_t col_in,
  output code_t   code
);

  // only the two newest columns are kept; the oldest falls out on a shift
  gray_t win1 [3];
  gray_t win2 [3];
  gray_t c0 [3];
  gray_t c1 [3];
  gray_t c2 [3];
  gray_t centre;

  always_ff @(posedge clk) begin
    if (rst) begin
      win1 <= '{default: '0};
      win2 <= '{default: '0};
    end else if (shift_en) begin
      win1 <= win2;
      win2 <= '{col_in.top, col_in.mid, col_in.cur};
    end
  end

  // window as it stands after this shift
  always_comb begin
    c0 = win1;
    c1 = win2;
    c2 = '{col_in.top, col_in.mid, col_in.cur};
    centre = c1[1];
  end

  // bit 0 above, then clockwise to bit 7 at top-left
  always_comb begin
    code[0] = centre < c1[0];
    code[1] = centre < c2[0];
    code[2] = centre < c2[1];
    code[3] = centre < c2[2];
    code[4] = centre < c1[2];
    code[5] = centre < c0[2];
    code[6] = centre < c0[1];
    code[7] = centre < c0[0];
  end

endmodule

### hw/rtl/lbp_code_3x3_stream_core.sv
// Top level of the 3x3 local binary pattern stream core.
// Takes one RGB pixel per clock when not stalled, in raster order over a
// square IMAGE_SIZE image, and returns one code per interior pixel once the
// pixel that completes its window has passed an input register that also
// holds the line store read, then the result register. Sustained rate is one
// pixel per clock while out_stall is low: the line store has one read and
// one write port, read when a pixel is taken and written as it leaves the
// input register. Border pixels give no result. frame_start restarts row and
// column at zero; without it the counters wrap after the last pixel of an image.
module lbp_code_3x3_stream_core import lbp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [PIX_W-1:0]   blue,
  input  logic [PIX_W-1:0]   green,
  input  logic [PIX_W-1:0]   red,
  input  logic               frame_start,
  output logic               out_valid,
  input  logic               out_stall,
  output code_t              code,
  output coord_t             row,
  output coord_t             col,
  output logic               last
);

  localparam cnt_t LAST_IDX = CNT_W'(IMAGE_SIZE - 1);

  logic               in_take;
  logic               s1_adv;
  cnt_t               row_count, row_count_next;
  cnt_t               col_count, col_count_next;
  cnt_t               row_cur, col_cur;
  gray_t              gray_in;
  logic               s1_valid;
  gray_t              s1_gray;
  cnt_t               s1_row, s1_col;
  logic [2*PIX_W-1:0] rd_data;
  column_t            new_col;
  code_t              win_code;
  logic               emit;

  assign s1_adv   = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !s1_adv;
  assign in_take  = in_valid && !in_stall;

  assign row_cur = frame_start ? '0 : row_count;
  assign col_cur = frame_start ? '0 : col_count;

  always_comb begin
    if (col_cur == LAST_IDX) begin
      col_count_next = '0;
      row_count_next = (row_cur == LAST_IDX) ? '0 : row_cur + 1'b1;
    end else begin
      col_count_next = col_cur + 1'b1;
      row_count_next = row_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= '0;
      col_count <= '0;
    end else if (in_take) begin
      row_count <= row_count_next;
      col_count <= col_count_next;
    end
  end

  lbp_gray u_gray (
    .blue  (blue),
    .green (green),
    .red   (red),
    .gray  (gray_in)
  );

  // input register; line store read data lines up with it
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_gray <= gray_in;
      s1_row  <= row_cur;
      s1_col  <= col_cur;
    end
  end

  lbp_line_store u_lines (
    .clk     (clk),
    .rd_en   (in_take),
    .rd_addr (col_cur),
    .rd_data (rd_data),
    .wr_en   (s1_adv),
    .wr_addr (s1_col),
    .wr_data ({rd_data[PIX_W-1:0], s1_gray})
  );

  assign new_col.top = rd_data[2*PIX_W-1:PIX_W];
  assign new_col.mid = rd_data[PIX_W-1:0];
  assign new_col.cur = s1_gray;

  lbp_window u_window (
    .clk      (clk),
    .rst      (rst),
    .shift_en (s1_adv),
    .col_in   (new_col),
    .code     (win_code)
  );

  assign emit = (s1_row >= CNT_W'(2)) && (s1_col >= CNT_W'(2));

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= emit;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      code <= win_code;
      row  <= COORD_W'(s1_row - 1'b1);
      col  <= COORD_W'(s1_col - 1'b1);
      last <= (s1_row == LAST_IDX) && (s1_col == LAST_IDX);
    end
  end

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && out_valid && out_stall)
    else $error("input stalled without a blocked result");

  a_frame_start_origin: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && frame_start |=> s1_row == '0 && s1_col == '0)
    else $error("frame start did not restart row and column");

  a_count_advance: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && !frame_start && col_count != LAST_IDX
    |=> col_count == $past(col_count) + 1'b1 && row_count == $past(row_count))
    else $error("column counter did not step by one");

endmodule

### verif/tb_lbp_code_3x3_stream_core.sv
// Self-checking testbench for the 3x3 local binary pattern stream core.
module tb_lbp_code_3x3_stream_core import lbp_pkg::*; ();

  localparam int     LONG_HOLD    = 400;
  localparam int     TAIL_CYCLES  = 20;
  localparam longint CYCLE_LIMIT  = 3_000_000;

  typedef enum int {IDLE_NONE, IDLE_SPARSE, IDLE_FULL} idle_mode_t;

  typedef struct {
    code_t  code;
    coord_t row;
    coord_t col;
    logic   last;
  } lbp_result_t;

  class lbp_scoreboard;
    gray_t         line_top [IMAGE_SIZE];
    gray_t         line_mid [IMAGE_SIZE];
    gray_t         win [3][3];
    int unsigned   row_cnt;
    int unsigned   col_cnt;
    lbp_result_t   pending_codes [$];
    int            errors;

    function new();
      foreach (line_top[i]) begin
        line_top[i] = '0;
        line_mid[i] = '0;
      end
      foreach (win[i, j]) win[i][j] = '0;
      row_cnt = 0;
      col_cnt = 0;
      errors  = 0;
    endfunction

    // Advance the window by one accepted pixel and queue the code it completes.
    function void take_pixel(logic [PIX_W-1:0] b, logic [PIX_W-1:0] g,
                             logic [PIX_W-1:0] r, logic fs);
      logic [SUM_W-1:0] sum;
      gray_t            gray;
      gray_t            above;
      gray_t            middle;
      gray_t            ctr;
      int unsigned      rw;
      int unsigned      cl;
      lbp_result_t      res;
      sum  = SUM_W'(b) + SUM_W'(g) + SUM_W'(r);
      gray = gray_t'(sum / 3);
      if (fs) begin
        row_cnt = 0;
        col_cnt = 0;
      end
      rw = row_cnt;
      cl = col_cnt;
      above  = line_top[cl];
      middle = line_mid[cl];
      line_top[cl] = middle;
      line_mid[cl] = gray;
      for (int k = 0; k < 3; k++) begin
        win[k][0] = win[k][1];
        win[k][1] = win[k][2];
      end
      win[0][2] = above;
      win[1][2] = middle;
      win[2][2] = gray;
      if (rw >= 2 && cl >= 2) begin
        ctr = win[1][1];
        // bit 0 is above, then clockwise to top-left at bit 7
        res.code = {ctr < win[0][0], ctr < win[1][0], ctr < win[2][0], ctr < win[2][1],
                    ctr < win[2][2], ctr < win[1][2], ctr < win[0][2], ctr < win[0][1]};
        res.row  = coord_t'(rw - 1);
        res.col  = coord_t'(cl - 1);
        res.last = (rw == IMAGE_SIZE - 1) && (cl == IMAGE_SIZE - 1);
        pending_codes.push_back(res);
      end
      if (cl + 1 >= IMAGE_SIZE) begin
        col_cnt = 0;
        row_cnt = (rw + 1 >= IMAGE_SIZE) ? 0 : rw + 1;
      end else begin
        col_cnt = cl + 1;
      end
    endfunction

    function void compare_field(string what, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch: expected %h, got %h", $time, what, want, got);
        errors++;
      end
    endfunction

    function void check_code(code_t c, coord_t rw, coord_t cl, logic lst);
      lbp_result_t want;
      if (pending_codes.size() == 0) begin
        $display("%0t: code %h row %0d col %0d arrived with nothing pending",
                 $time, c, rw, cl);
        errors++;
        return;
      end
      want = pending_codes.pop_front();
      compare_field("code", want.code, c);
      compare_field("row", 8'(want.row), 8'(rw));
      compare_field("col", 8'(want.col), 8'(cl));
      compare_field("last", 8'(want.last), 8'(lst));
    endfunction

    function int outstanding();
      return pending_codes.size();
    endfunction
  endclass

  logic             clk         = 1'b0;
  logic             rst         = 1'b1;
  logic             in_valid    = 1'b0;
  logic             in_stall;
  logic [PIX_W-1:0] blue        = '0;
  logic [PIX_W-1:0] green       = '0;
  logic [PIX_W-1:0] red         = '0;
  logic             frame_start = 1'b0;
  logic             out_valid;
  logic             out_stall   = 1'b0;
  code_t            code;
  coord_t           row;
  coord_t           col;
  logic             last;

  lbp_scoreboard board = new();
  idle_mode_t    sender_mode = IDLE_NONE;
  idle_mode_t    recv_mode   = IDLE_NONE;
  bit            long_hold_req = 1'b0;
  longint        cycles = 0;

  lbp_code_3x3_stream_core uut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .blue        (blue),
    .green       (green),
    .red         (red),
    .frame_start (frame_start),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .code        (code),
    .row         (row),
    .col         (col),
    .last        (last)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_lbp_code_3x3_stream_core: errors");
      $finish;
    end
  end

  function automatic int draw_wait(idle_mode_t mode);
    case (mode)
      IDLE_NONE:   return 0;
      IDLE_SPARSE: return ($urandom_range(0, 15) == 0) ? $urandom_range(0, 19) : 0;
      default:     return $urandom_range(0, 19);
    endcase
  endfunction

  // valid stays high from one request to the next unless a gap is drawn
  task automatic send_pixel(input logic [PIX_W-1:0] b, input logic [PIX_W-1:0] g,
                            input logic [PIX_W-1:0] r, input logic fs);
    int gap;
    gap = draw_wait(sender_mode);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    blue        <= b;
    green       <= g;
    red         <= r;
    frame_start <= fs;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.take_pixel(b, g, r, fs);
  endtask

  // mix of full-range, nearly flat (many equal grays) and saturated pixels
  task automatic send_random(input logic fs);
    int               pick;
    logic [PIX_W-1:0] base;
    pick = $urandom_range(0, 9);
    if (pick < 5) begin
      send_pixel(PIX_W'($urandom_range(0, 255)), PIX_W'($urandom_range(0, 255)),
                 PIX_W'($urandom_range(0, 255)), fs);
    end else if (pick < 8) begin
      base = PIX_W'(100 + $urandom_range(0, 2));
      send_pixel(base, base, base, fs);
    end else begin
      send_pixel(PIX_W'($urandom_range(0, 1) * 255), PIX_W'($urandom_range(0, 1) * 255),
                 PIX_W'($urandom_range(0, 1) * 255), fs);
    end
  endtask

  task automatic send_frame(input logic fs, input int count);
    for (int i = 0; i < count; i++) send_random(fs && i == 0);
  endtask

  initial begin : result_sink
    int hold;
    while (rst) @(posedge clk);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold = LONG_HOLD;
      end else begin
        hold = draw_wait(recv_mode);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      board.check_code(code, row, col, last);
    end
  end

  initial begin : pixel_source
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // field extremes, rounding of the gray divide, restarts mid-row
    send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);
    send_pixel(8'h00, 8'h00, 8'h00, 1'b0);
    send_pixel(8'hFF, 8'h00, 8'h00, 1'b0);
    send_pixel(8'h00, 8'hFF, 8'h00, 1'b0);
    send_pixel(8'h00, 8'h00, 8'hFF, 1'b0);
    send_pixel(8'h01, 8'h01, 8'h00, 1'b0);
    send_pixel(8'hFF, 8'hFF, 8'hFE, 1'b0);
    send_pixel(8'hAA, 8'h55, 8'hFF, 1'b0);
    send_pixel(8'h55, 8'hAA, 8'h00, 1'b1);
    send_pixel(8'h00, 8'h00, 8'h00, 1'b1);
    send_pixel(8'h80, 8'h7F, 8'h01, 1'b1);

    sender_mode = IDLE_FULL;
    recv_mode   = IDLE_FULL;
    send_frame(1'b1, 3 * IMAGE_SIZE + $urandom_range(0, IMAGE_SIZE - 1));

    // new frame breaks in mid-row; source never idles while the sink holds off
    sender_mode   = IDLE_NONE;
    recv_mode     = IDLE_NONE;
    long_hold_req = 1'b1;
    send_frame(1'b1, 3 * IMAGE_SIZE + $urandom_range(0, IMAGE_SIZE - 1));

    // hold the source until every pending code is out
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.outstanding() != 0) @(posedge clk);

    sender_mode = IDLE_FULL;
    recv_mode   = IDLE_SPARSE;
    send_frame(1'b1, 2 * IMAGE_SIZE + $urandom_range(IMAGE_SIZE / 2, IMAGE_SIZE - 1));

    // noise: frame starts at arbitrary points
    sender_mode = IDLE_SPARSE;
    recv_mode   = IDLE_SPARSE;
    for (int i = 0; i < 300; i++) send_random($urandom_range(0, 39) == 0);

    in_valid <= 1'b0;
    recv_mode = IDLE_NONE;
    while (board.outstanding() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (board.errors == 0) begin
      $display("tb_lbp_code_3x3_stream_core: clean");
    end else begin
      $display("tb_lbp_code_3x3_stream_core: errors");
    end
    $finish;
  end

endmodule
